@@ src/jsu_pkg.sv @@
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

    localparam int QUEUE_DEPTH  = 4;
    localparam int PACKET_BYTES = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PIDX_W       = $clog2(PACKET_BYTES);

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd1;
    localparam logic [2:0] ERR_BAD_UNICODE  = 3'd2;
    localparam logic [2:0] ERR_BAD_SURROGATE = 3'd3;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
        logic       last;
    } out_item_t;

    // All results caused by one input byte, bytes[0] first.
    typedef struct packed {
        logic [PACKET_BYTES-1:0][7:0] bytes;
        logic [PIDX_W:0]              count;
        logic [1:0]                   kind;
        logic [2:0]                   error_code;
    } packet_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ src/json_string_unescape_utf8_unit.sv @@
// Top level of the JSON string unescaper with UTF-8 output.
//
// The block takes the bytes of a JSON string body, starting just after the
// opening quote, and delivers decoded UTF-8 bytes, an end result at the closing
// quote, or an error result, after which it is back in content mode for the
// next string. One input byte is taken per clock cycle whenever full is low;
// the front end decodes each byte combinationally and files all the results
// it causes (none to four) as one packet in a four-entry queue. The back end
// hands out one result per cycle from its output register while pop is held,
// so the first result of a request passes through the queue and the output
// register before it reaches the result ports. Sustained throughput is set
// by the input bytes or by the results, whichever are more numerous: a
// completed unicode escape that yields several UTF-8 bytes holds the output
// register while they are handed out, and full rises only once the queue has
// filled behind it. The last flag marks the final result of any input byte.
module json_string_unescape_utf8_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  jsu_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output jsu_pkg::out_item_t result
);

    jsu_pkg::q_status_t q_stat;
    jsu_pkg::packet_t   front_pkt;
    jsu_pkg::packet_t   head_pkt;
    logic               front_push;
    logic               back_pop;

    // The front end stalls only on a full queue, never on the result side.
    assign full = q_stat.full;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .q_stat   (q_stat),
        .pkt_push (front_push),
        .pkt      (front_pkt)
    );

    jsu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .pkt_in  (front_pkt),
        .pop     (back_pop),
        .pkt_out (head_pkt),
        .status  (q_stat)
    );

    jsu_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt    (head_pkt),
        .q_stat (q_stat),
        .q_pop  (back_pop),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

@@ src/jsu_front.sv @@
// Front end: accepts raw bytes, tracks escape state and builds result packets.
module jsu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jsu_pkg::in_item_t  item,
    input  jsu_pkg::q_status_t q_stat,
    output logic               pkt_push,
    output jsu_pkg::packet_t   pkt
);

    localparam logic [2:0] M_CONTENT   = 3'd0;
    localparam logic [2:0] M_ESCAPE    = 3'd1;
    localparam logic [2:0] M_HEX_FIRST = 3'd2;
    localparam logic [2:0] M_WANT_BSL  = 3'd3;
    localparam logic [2:0] M_WANT_U    = 3'd4;
    localparam logic [2:0] M_HEX_LOW   = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [15:0] ONE_MAX    = 16'h007F;
    localparam logic [15:0] TWO_MAX    = 16'h07FF;

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [15:0] code_word_reg, code_word_next;
    logic [9:0]  high_half_reg, high_half_next;

    logic        accept;
    logic        emit;
    logic        go_idle;
    logic        hex_ok;
    logic [3:0]  hex_value;
    logic [15:0] word;
    logic [20:0] supp_cp;

    function automatic jsu_pkg::packet_t single(input logic [7:0] b, input logic [1:0] k,
                                                input logic [2:0] e);
        jsu_pkg::packet_t p;
        p            = '0;
        p.bytes[0]   = b;
        p.count      = 3'd1;
        p.kind       = k;
        p.error_code = e;
        return p;
    endfunction

    function automatic jsu_pkg::packet_t encode_bmp(input logic [15:0] v);
        jsu_pkg::packet_t p;
        p      = '0;
        p.kind = jsu_pkg::KIND_DATA;
        if (v <= ONE_MAX) begin
            p.bytes[0] = v[7:0];
            p.count    = 3'd1;
        end
        else if (v <= TWO_MAX) begin
            p.bytes[0] = {3'b110, v[10:6]};
            p.bytes[1] = {2'b10, v[5:0]};
            p.count    = 3'd2;
        end
        else begin
            p.bytes[0] = {4'b1110, v[15:12]};
            p.bytes[1] = {2'b10, v[11:6]};
            p.bytes[2] = {2'b10, v[5:0]};
            p.count    = 3'd3;
        end
        return p;
    endfunction

    function automatic jsu_pkg::packet_t encode_supp(input logic [20:0] cp);
        jsu_pkg::packet_t p;
        p          = '0;
        p.kind     = jsu_pkg::KIND_DATA;
        p.bytes[0] = {5'b11110, cp[20:18]};
        p.bytes[1] = {2'b10, cp[17:12]};
        p.bytes[2] = {2'b10, cp[11:6]};
        p.bytes[3] = {2'b10, cp[5:0]};
        p.count    = 3'd4;
        return p;
    endfunction

    assign accept = push && !q_stat.full;

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_value = 4'd0;
        if (item.data_byte >= 8'h30 && item.data_byte <= 8'h39)
        begin
            hex_value = item.data_byte[3:0];
        end
        else if ((item.data_byte >= 8'h61 && item.data_byte <= 8'h66) ||
                 (item.data_byte >= 8'h41 && item.data_byte <= 8'h46))
        begin
            hex_value = item.data_byte[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign word    = {code_word_reg[11:0], hex_value};
    // The low ten bits of each half are the offsets from the range bases.
    assign supp_cp = {1'b0, high_half_reg, word[9:0]} + SUPP_BASE;

    always_comb
    begin
        mode_next        = mode_reg;
        digit_count_next = digit_count_reg;
        code_word_next   = code_word_reg;
        high_half_next   = high_half_reg;
        pkt              = '0;
        emit             = 1'b0;
        go_idle          = 1'b0;

        if (item.end_of_text)
        begin
            emit    = 1'b1;
            go_idle = 1'b1;
            unique case (mode_reg)
                M_ESCAPE:
                    pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_ESCAPE);
                M_HEX_FIRST, M_HEX_LOW:
                    pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_UNICODE);
                M_WANT_BSL, M_WANT_U:
                    pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_SURROGATE);
                default:
                    pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERMINATED);
            endcase
        end
        else
        begin
            unique case (mode_reg)
                M_ESCAPE:
                begin
                    emit = 1'b1;
                    mode_next = M_CONTENT;
                    unique case (item.data_byte)
                        CH_U:
                        begin
                            emit             = 1'b0;
                            mode_next        = M_HEX_FIRST;
                            digit_count_next = 2'd0;
                            code_word_next   = 16'd0;
                        end
                        CH_QUOTE, CH_BSL, CH_SLASH:
                            pkt = single(item.data_byte, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                        CH_B: pkt = single(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                        CH_F: pkt = single(8'h0C, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                        CH_N: pkt = single(8'h0A, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                        CH_R: pkt = single(8'h0D, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                        CH_T: pkt = single(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                        default:
                        begin
                            pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_ESCAPE);
                            go_idle = 1'b1;
                        end
                    endcase
                end
                M_HEX_FIRST, M_HEX_LOW:
                begin
                    if (!hex_ok)
                    begin
                        emit    = 1'b1;
                        go_idle = 1'b1;
                        pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_UNICODE);
                    end
                    else if (digit_count_reg != 2'd3)
                    begin
                        code_word_next   = word;
                        digit_count_next = digit_count_reg + 2'd1;
                    end
                    else if (mode_reg == M_HEX_FIRST)
                    begin
                        if (word >= HIGH_FIRST && word <= HIGH_LAST)
                        begin
                            high_half_next   = word[9:0];
                            mode_next        = M_WANT_BSL;
                            digit_count_next = 2'd0;
                            code_word_next   = 16'd0;
                        end
                        else if (word >= LOW_FIRST && word <= LOW_LAST)
                        begin
                            emit    = 1'b1;
                            go_idle = 1'b1;
                            pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_SURROGATE);
                        end
                        else
                        begin
                            emit    = 1'b1;
                            go_idle = 1'b1;
                            pkt     = encode_bmp(word);
                        end
                    end
                    else
                    begin
                        emit    = 1'b1;
                        go_idle = 1'b1;
                        if (word >= LOW_FIRST && word <= LOW_LAST)
                        begin
                            pkt = encode_supp(supp_cp);
                        end
                        else
                        begin
                            pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_SURROGATE);
                        end
                    end
                end
                M_WANT_BSL:
                begin
                    if (item.data_byte == CH_BSL)
                    begin
                        mode_next = M_WANT_U;
                    end
                    else
                    begin
                        emit    = 1'b1;
                        go_idle = 1'b1;
                        pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_SURROGATE);
                    end
                end
                M_WANT_U:
                begin
                    if (item.data_byte == CH_U)
                    begin
                        mode_next        = M_HEX_LOW;
                        digit_count_next = 2'd0;
                        code_word_next   = 16'd0;
                    end
                    else
                    begin
                        emit    = 1'b1;
                        go_idle = 1'b1;
                        pkt = single(8'd0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_SURROGATE);
                    end
                end
                default:
                begin
                    if (item.data_byte == CH_QUOTE)
                    begin
                        emit    = 1'b1;
                        go_idle = 1'b1;
                        pkt     = single(8'd0, jsu_pkg::KIND_END, jsu_pkg::ERR_NONE);
                    end
                    else if (item.data_byte == CH_BSL)
                    begin
                        mode_next = M_ESCAPE;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        mode_next = M_CONTENT;
                        pkt = single(item.data_byte, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                    end
                end
            endcase
        end

        if (go_idle)
        begin
            mode_next        = M_CONTENT;
            digit_count_next = 2'd0;
            code_word_next   = 16'd0;
            high_half_next   = 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_CONTENT;
            digit_count_reg <= 2'd0;
            code_word_reg   <= 16'd0;
            high_half_reg   <= 10'd0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            digit_count_reg <= digit_count_next;
            code_word_reg   <= code_word_next;
            high_half_reg   <= high_half_next;
        end
    end

    assign pkt_push = accept && emit;

    // A pushed packet always carries between one and four results.
    a_pkt_count: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_push |-> (pkt.count != 3'd0 && pkt.count <= 3'd4))
        else $error("front pushed a packet with a bad result count");

endmodule

@@ src/jsu_queue.sv @@
// Short packet queue between the front end and the result serialiser.
module jsu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jsu_pkg::packet_t   pkt_in,
    input  logic               pop,
    output jsu_pkg::packet_t   pkt_out,
    output jsu_pkg::q_status_t status
);

    jsu_pkg::packet_t mem [jsu_pkg::QUEUE_DEPTH];

    logic [jsu_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [jsu_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [jsu_pkg::QCNT_W-1:0] count_reg;
    logic                       do_push;
    logic                       do_pop;

    localparam logic [jsu_pkg::QPTR_W-1:0] PTR_LAST = jsu_pkg::QPTR_W'(jsu_pkg::QUEUE_DEPTH - 1);
    localparam logic [jsu_pkg::QCNT_W-1:0] CNT_FULL = jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH);

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pkt_out      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= pkt_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + jsu_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + jsu_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + jsu_pkg::QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - jsu_pkg::QCNT_W'(1);
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("packet queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg == rd_ptr_reg) |-> (status.empty || status.full))
        else $error("packet queue pointers disagree with count");

endmodule

@@ src/jsu_back.sv @@
// Back end: splits queued packets into single results held in an output register.
module jsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  jsu_pkg::packet_t   pkt,
    input  jsu_pkg::q_status_t q_stat,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output jsu_pkg::out_item_t result
);

    jsu_pkg::out_item_t          out_reg;
    logic                        out_valid_reg;
    logic [jsu_pkg::PIDX_W-1:0]  idx_reg;
    logic                        load;
    logic                        final_one;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign load      = !out_valid_reg || pop;
    assign final_one = ({1'b0, idx_reg} == (pkt.count - (jsu_pkg::PIDX_W + 1)'(1)));
    assign q_pop     = load && !q_stat.empty && final_one;

    always_ff @(posedge clk)
    begin
        if (load && !q_stat.empty)
        begin
            out_reg.out_byte   <= pkt.bytes[idx_reg];
            out_reg.kind       <= pkt.kind;
            out_reg.error_code <= pkt.error_code;
            out_reg.last       <= final_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= !q_stat.empty;
            if (!q_stat.empty)
            begin
                idx_reg <= final_one ? '0 : idx_reg + jsu_pkg::PIDX_W'(1);
            end
        end
    end

    a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != jsu_pkg::KIND_DATA) |-> result.last)
        else $error("end or error result not marked last");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.kind == jsu_pkg::KIND_ERROR) ==
                    (result.error_code != jsu_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

endmodule

@@ test/jsu_result_checker.sv @@
// Checker for the JSON string unescaper: it predicts every result and compares it on arrival.
module jsu_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  jsu_pkg::in_item_t  item,
    input  logic               empty,
    input  logic               pop,
    input  jsu_pkg::out_item_t result,
    output int                 fail_count,
    output int                 pending
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [2:0] ST_TEXT      = 3'd0;
    localparam logic [2:0] ST_ESCAPE    = 3'd1;
    localparam logic [2:0] ST_HEX_FIRST = 3'd2;
    localparam logic [2:0] ST_WANT_BSL  = 3'd3;
    localparam logic [2:0] ST_WANT_U    = 3'd4;
    localparam logic [2:0] ST_HEX_LOW   = 3'd5;

    logic [2:0]         dec_state;
    logic [1:0]         digit_cnt;
    logic [15:0]        hex_word;
    logic [15:0]        high_word;
    int                 mismatch_total;
    jsu_pkg::out_item_t decoded_q[$];
    jsu_pkg::out_item_t step_q[$];

    function automatic void back_to_text();
        dec_state = ST_TEXT;
        digit_cnt = 2'd0;
        hex_word  = 16'h0000;
        high_word = 16'h0000;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic [1:0] k, input logic [2:0] e);
        jsu_pkg::out_item_t r;
        r.out_byte   = b;
        r.kind       = k;
        r.error_code = e;
        r.last       = 1'b0;
        step_q       = {step_q, r};
    endfunction

    function automatic void flag_error(input logic [2:0] e);
        back_to_text();
        emit(8'h00, jsu_pkg::KIND_ERROR, e);
    endfunction

    function automatic void emit_utf8(input logic [20:0] cp);
        back_to_text();
        if (cp <= 21'h7F) begin
            emit(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
        else if (cp <= 21'h7FF) begin
            emit({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
        else if (cp <= 21'hFFFF) begin
            emit({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
        else begin
            emit({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
    endfunction

    // Bit 4 set means the byte is a hex digit; bits 3:0 then hold its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
        if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h57)};
        if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h37)};
        return 5'b00000;
    endfunction

    task automatic predict_request(input jsu_pkg::in_item_t req);
        logic [4:0]  nib;
        logic [15:0] word;
        logic [7:0]  b;
        b = req.data_byte;
        step_q.delete();
        if (req.end_of_text) begin
            case (dec_state)
                ST_ESCAPE:               flag_error(jsu_pkg::ERR_BAD_ESCAPE);
                ST_HEX_FIRST, ST_HEX_LOW: flag_error(jsu_pkg::ERR_BAD_UNICODE);
                ST_WANT_BSL, ST_WANT_U:   flag_error(jsu_pkg::ERR_BAD_SURROGATE);
                default:                 flag_error(jsu_pkg::ERR_UNTERMINATED);
            endcase
        end
        else begin
            case (dec_state)
                ST_ESCAPE: begin
                    if (b == CH_U) begin
                        dec_state = ST_HEX_FIRST;
                        digit_cnt = 2'd0;
                        hex_word  = 16'h0000;
                    end
                    else begin
                        dec_state = ST_TEXT;
                        case (b)
                            CH_QUOTE, CH_BSL, CH_SLASH:
                                emit(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                            CH_B: emit(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                            CH_F: emit(8'h0C, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                            CH_N: emit(8'h0A, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                            CH_R: emit(8'h0D, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                            CH_T: emit(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                            default: flag_error(jsu_pkg::ERR_BAD_ESCAPE);
                        endcase
                    end
                end
                ST_HEX_FIRST, ST_HEX_LOW: begin
                    nib = hex_nibble(b);
                    if (!nib[4]) begin
                        flag_error(jsu_pkg::ERR_BAD_UNICODE);
                    end
                    else begin
                        word     = {hex_word[11:0], nib[3:0]};
                        hex_word = word;
                        if (digit_cnt != 2'd3) begin
                            digit_cnt = digit_cnt + 2'd1;
                        end
                        else if (dec_state == ST_HEX_FIRST) begin
                            if (word >= 16'hD800 && word <= 16'hDBFF) begin
                                high_word = word;
                                dec_state = ST_WANT_BSL;
                                digit_cnt = 2'd0;
                                hex_word  = 16'h0000;
                            end
                            else if (word >= 16'hDC00 && word <= 16'hDFFF) begin
                                flag_error(jsu_pkg::ERR_BAD_SURROGATE);
                            end
                            else begin
                                emit_utf8({5'd0, word});
                            end
                        end
                        else if (word < 16'hDC00 || word > 16'hDFFF) begin
                            flag_error(jsu_pkg::ERR_BAD_SURROGATE);
                        end
                        else begin
                            emit_utf8(21'h10000 + {1'b0, high_word[9:0], word[9:0]});
                        end
                    end
                end
                ST_WANT_BSL: begin
                    if (b == CH_BSL) dec_state = ST_WANT_U;
                    else flag_error(jsu_pkg::ERR_BAD_SURROGATE);
                end
                ST_WANT_U: begin
                    if (b == CH_U) begin
                        dec_state = ST_HEX_LOW;
                        digit_cnt = 2'd0;
                        hex_word  = 16'h0000;
                    end
                    else begin
                        flag_error(jsu_pkg::ERR_BAD_SURROGATE);
                    end
                end
                default: begin
                    if (b == CH_QUOTE) begin
                        back_to_text();
                        emit(8'h00, jsu_pkg::KIND_END, jsu_pkg::ERR_NONE);
                    end
                    else if (b == CH_BSL) begin
                        dec_state = ST_ESCAPE;
                    end
                    else begin
                        dec_state = ST_TEXT;
                        emit(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                    end
                end
            endcase
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        decoded_q = {decoded_q, step_q};
    endtask

    task automatic report_mismatch(input string what, input jsu_pkg::out_item_t got,
                                   input jsu_pkg::out_item_t want);
        $display("mismatch %s: got %h/%0d/%0d/%b want %h/%0d/%0d/%b",
                 what, got.out_byte, got.kind, got.error_code, got.last,
                 want.out_byte, want.kind, want.error_code, want.last);
        mismatch_total++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        jsu_pkg::out_item_t want;
        if (!rst_n) begin
            back_to_text();
            decoded_q.delete();
            mismatch_total = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            // Results pass through the queue and the output register after their
            // request, so the result is checked before this cycle's request is predicted.
            if (pop && !empty) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with nothing expected", result, '0);
                end
                else begin
                    want = decoded_q.pop_front();
                    if (result.out_byte !== want.out_byte || result.kind !== want.kind ||
                        result.error_code !== want.error_code || result.last !== want.last)
                        report_mismatch("result differs", result, want);
                end
            end
            if (push && !full) predict_request(item);
            fail_count <= mismatch_total;
            pending    <= decoded_q.size();
        end
    end

endmodule

@@ test/tb_json_string_unescape_utf8_unit.sv @@
// Testbench top for the JSON string unescaper: stimulus, idling, watchdog and verdict.
module tb_json_string_unescape_utf8_unit;

    // A well-behaved run never goes this long without a request or a result
    // being accepted.
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 150;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    jsu_pkg::in_item_t  item;
    logic               empty;
    logic               pop;
    jsu_pkg::out_item_t result;
    int                 fail_count;
    int                 pending;

    // While steady is set neither side idles, so the queue runs at full rate.
    bit         steady;
    int         items_sent;
    int         idle_cycles;
    // One fragment of string text; bit 8 marks an end of text request.
    logic [8:0] piece[$];

    json_string_unescape_utf8_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    jsu_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Every task below is entered and left just after a falling edge. A
    // request that follows without a gap keeps push high, so push is never
    // lowered and raised again within one time step.
    task automatic send_request(input logic [7:0] b, input logic eot);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item = '{data_byte: b, end_of_text: eot};
        push = 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    endtask

    // The data byte of an end of text request is ignored, so it is random.
    task automatic send_eot();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Hold the sender off until every expected result has been taken.
    task automatic wait_drained();
        push = 1'b0;
        do @(posedge clk); while (pending != 0);
        @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        // Letters come in either case, as the decoder must accept both.
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] escape_letter(input int i);
        case (i)
            0:       return 8'h22;
            1:       return 8'h5C;
            2:       return 8'h2F;
            3:       return 8'h62;
            4:       return 8'h66;
            5:       return 8'h6E;
            6:       return 8'h72;
            default: return 8'h74;
        endcase
    endfunction

    // A code point outside the surrogate range, spread over the one, two and
    // three byte forms, with the boundaries of each form now and then.
    function automatic logic [15:0] pick_scalar();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 16'($urandom_range(0, 16'h7F));
        if (r < 6) return 16'($urandom_range(16'h80, 16'h7FF));
        if (r < 9)
        begin
            if ($urandom_range(0, 1)) return 16'($urandom_range(16'h800, 16'hD7FF));
            return 16'($urandom_range(16'hE000, 16'hFFFF));
        end
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h007F;
            2:       return 16'h0080;
            3:       return 16'h07FF;
            4:       return 16'h0800;
            5:       return 16'hD7FF;
            6:       return 16'hE000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_half(input logic [15:0] lo, input logic [15:0] hi);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return 16'($urandom_range(lo, hi));
    endfunction

    // Add one entry at the end of the fragment being built.
    function automatic void append_piece(input logic [8:0] v);
        piece = {piece, v};
    endfunction

    function automatic void add_u_escape(input logic [15:0] w);
        append_piece({1'b0, CH_BSL});
        append_piece({1'b0, CH_U});
        for (int i = 3; i >= 0; i--) append_piece({1'b0, hex_char(w[i*4 +: 4])});
    endfunction

    // A well-formed escape of one of the three kinds.
    function automatic void add_good_escape();
        case ($urandom_range(0, 2))
            0:
            begin
                append_piece({1'b0, CH_BSL});
                append_piece({1'b0, escape_letter($urandom_range(0, 7))});
            end
            1:       add_u_escape(pick_scalar());
            default:
            begin
                add_u_escape(pick_half(16'hD800, 16'hDBFF));
                add_u_escape(pick_half(16'hDC00, 16'hDFFF));
            end
        endcase
    endfunction

    // Build the next fragment: mostly well-formed text, the rest broken.
    function automatic void build_piece();
        int r;
        int pos;
        logic [7:0] b;
        piece.delete();
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            // A plain byte; quote and backslash have pieces of their own.
            b = 8'($urandom_range(0, 255));
            if (b == CH_QUOTE || b == CH_BSL) b = b ^ 8'h01;
            append_piece({1'b0, b});
        end
        else if (r < 70)
        begin
            add_good_escape();
        end
        else if (r < 77)
        begin
            append_piece({1'b0, CH_QUOTE});
        end
        else if (r < 82)
        begin
            // End of text in the middle of ordinary content.
            append_piece(9'h100);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    // Cut a good escape short by the end of the text.
                    add_good_escape();
                    pos = $urandom_range(1, piece.size() - 1);
                    piece = piece[0:pos-1];
                    append_piece(9'h100);
                end
                1:
                begin
                    // Replace one byte of a good escape by any byte at all.
                    add_good_escape();
                    pos = $urandom_range(0, piece.size() - 1);
                    piece[pos] = {1'b0, 8'($urandom_range(0, 255))};
                end
                2:       add_u_escape(pick_half(16'hDC00, 16'hDFFF));
                3:
                begin
                    // A high half followed by a word that is not a low half.
                    add_u_escape(pick_half(16'hD800, 16'hDBFF));
                    if ($urandom_range(0, 1)) add_u_escape(pick_scalar());
                    else add_u_escape(pick_half(16'hD800, 16'hDBFF));
                end
                default:
                begin
                    add_u_escape(pick_half(16'hD800, 16'hDBFF));
                    append_piece({1'b0, 8'($urandom_range(0, 255))});
                end
            endcase
        end
    endfunction

    task automatic run_random();
        int base;
        int pieces;
        base   = items_sent;
        pieces = 0;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            steady = (items_sent - base >= 60) && (items_sent - base < 100);
            build_piece();
            foreach (piece[i])
            begin
                if (piece[i][8]) send_eot();
                else send_request(piece[i][7:0], 1'b0);
            end
            pieces++;
            if (pieces % 20 == 0) wait_drained();
        end
        steady = 1'b0;
    endtask

    task automatic run_directed();
        // Extremes of the byte range, a closing quote and a simple escape.
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_text("\"");
        send_text("\\n");
        // An escape left pending at the end of the text.
        send_text("\\");
        send_eot();
        // A hex word cut off by the end of the text, then a non-hex digit.
        send_text("\\u1");
        send_eot();
        send_text("\\ug");
        // A lone low surrogate, then a high one followed by an ordinary byte.
        send_text("\\uDC00");
        send_text("\\uD83Dx");
        // End of text in content mode.
        send_eot();
    endtask

    // The receiver takes results with random stalls of its own.
    initial
    begin
        int stall;
        pop   = 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                pop = 1'b0;
                stall--;
            end
            else
            begin
                pop   = 1'b1;
                stall = steady ? 0 : pick_gap();
            end
        end
    end

    // Watchdog: ends the run when nothing at all is accepted for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        push       = 1'b0;
        item       = '0;
        steady     = 1'b0;
        items_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        wait_drained();
        run_random();

        // Let every expected result arrive, then watch a little longer for
        // any stray result the block might still deliver.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ json_string_unescape_utf8_unit.f @@
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8_unit.sv
test/jsu_result_checker.sv
test/tb_json_string_unescape_utf8_unit.sv
